>>> rtl/rgbpg_pkg.sv
// ----------------------------------------------------------------------------
// rgbpg_pkg
// Types, codes and fixed tables shared by the RGB LED pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbpg_pkg;

	localparam int DEF_PATTERN_STEPS = 32;
	localparam int DEF_PHASE_BITS    = 16;

	// Waveform mode codes of a request; the remaining codes give a constant level.
	localparam logic [2:0] MODE_CONST     = 3'd0;
	localparam logic [2:0] MODE_FALL_WAVE = 3'd1;
	localparam logic [2:0] MODE_RISE_WAVE = 3'd2;
	localparam logic [2:0] MODE_RISE_RAMP = 3'd3;
	localparam logic [2:0] MODE_FALL_RAMP = 3'd4;

	typedef enum logic [1:0] {
		SHAPE_CONST,
		SHAPE_WAVE,
		SHAPE_RAMP
	} shape_t;

	// Raised cosine values span 0..65534 and adjacent table points differ by
	// at most 3212, so the interpolation step fits in 12 bits.
	localparam int         RAISED_W = 16;
	localparam int         DIFF_W   = 12;
	localparam logic [15:0] COS_MID  = 16'd32767;
	localparam logic [16:0] WAVE_DIV = 17'd65534;

	// Delay conversion: floor(ms * 16 / 1000) = floor(2 * ms / 125).
	localparam logic [15:0] DELAY_SAT_MS = 16'd16000;
	localparam logic [15:0] RECIP_125    = 16'd33555;

	typedef struct packed {
		logic [2:0]  pattern_mode;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] red_shift;
		logic [15:0] green_shift;
		logic [15:0] blue_shift;
		logic [15:0] start_delay_ms;
		logic [15:0] repeat_delay_ms;
		logic [7:0]  smoothing;
	} req_t;

	typedef struct packed {
		logic [4:0] step_index;
		logic [7:0] red_level;
		logic [7:0] green_level;
		logic [7:0] blue_level;
		logic [7:0] delay_code;
		logic [7:0] repeat_code;
		logic [7:0] smooth_code;
		logic       last_step;
	} step_t;

	// Per-step information that rides along the level pipeline.
	typedef struct packed {
		logic [4:0]      step_index;
		logic            last_step;
		shape_t          shape;
		logic            ramp_fall;
		logic [2:0][7:0] colour;
		logic [7:0]      delay_code;
		logic [7:0]      repeat_code;
		logic [7:0]      smooth_code;
	} side_t;

	// First quadrant of the cosine in Q1.15, 16 intervals.
	function automatic logic [15:0] quarter_cos(input logic [4:0] k);
		logic [15:0] v;
		case (k)
			5'd0:    v = 16'd32767;
			5'd1:    v = 16'd32609;
			5'd2:    v = 16'd32137;
			5'd3:    v = 16'd31356;
			5'd4:    v = 16'd30273;
			5'd5:    v = 16'd28898;
			5'd6:    v = 16'd27245;
			5'd7:    v = 16'd25329;
			5'd8:    v = 16'd23170;
			5'd9:    v = 16'd20787;
			5'd10:   v = 16'd18204;
			5'd11:   v = 16'd15446;
			5'd12:   v = 16'd12539;
			5'd13:   v = 16'd9512;
			5'd14:   v = 16'd6393;
			5'd15:   v = 16'd3212;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	// Point j of 64 per turn of cosine plus one half scale.
	function automatic logic [15:0] raised_point(input logic [5:0] j);
		logic [4:0]  k;
		logic [4:0]  km;
		logic [15:0] v;
		k  = {1'b0, j[3:0]};
		km = 5'd16 - k;
		unique case (j[5:4])
			2'd0: v = COS_MID + quarter_cos(k);
			2'd1: v = COS_MID - quarter_cos(km);
			2'd2: v = COS_MID - quarter_cos(k);
			2'd3: v = COS_MID + quarter_cos(km);
		endcase
		return v;
	endfunction

	// Milliseconds to sixteenths of a second, saturated. Below the saturation
	// point 2*ms stays under 32000, where the rounded-up reciprocal is exact.
	function automatic logic [7:0] delay_code(input logic [15:0] ms);
		logic [14:0] y;
		logic [30:0] prod;
		y    = {ms[13:0], 1'b0};
		prod = {16'b0, y} * {15'b0, RECIP_125};
		return (ms >= DELAY_SAT_MS) ? 8'hFF : prod[29:22];
	endfunction

endpackage

`default_nettype wire

>>> rtl/rgb_led_pattern_generator.sv
// ----------------------------------------------------------------------------
// rgb_led_pattern_generator
// Expands one LED pattern request into a sequence of per-step RGB levels.
// ----------------------------------------------------------------------------
// Usage: a request word (mode, colour, per-channel phase shifts, delays and
// smoothing) enters on req_valid/req_ready. The block answers with
// PATTERN_STEPS step words on step_valid/step_ready, step 0 first, the last
// one flagged by last_step.
// A step sequencer issues one step per cycle, while the output does not
// stall, into a six-stage level pipeline (phase add, table lookup,
// interpolation multiply, interpolation add, colour multiply, scaling)
// whose last stage drives the step word. A request holds the sequencer
// until its last step is issued; the next request is taken in the cycle
// its predecessor's last step is issued, so patterns stream without a gap.
// When the receiver holds step_ready low while a step word is shown, the
// whole pipeline and the sequencer freeze; nothing is lost or repeated.
// Reset clears the sequencer and all pipeline valid bits; the block is ready
// for a request in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_pattern_generator #(
	parameter int PATTERN_STEPS = rgbpg_pkg::DEF_PATTERN_STEPS,
	parameter int PHASE_BITS    = rgbpg_pkg::DEF_PHASE_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire rgbpg_pkg::req_t   req,
	output logic                   step_valid,
	input  wire logic              step_ready,
	output rgbpg_pkg::step_t       step
);

	localparam int STEP_W = $clog2(PATTERN_STEPS);
	localparam int REM_W  = STEP_W + 1;
	localparam int FW     = PHASE_BITS - 6;
	localparam int OPW    = (PHASE_BITS + 1 > 16) ? PHASE_BITS + 1 : 16;
	localparam int XW     = OPW + 8;
	localparam int PW     = rgbpg_pkg::DIFF_W + FW;

	// Per-step phase increments as quotient and remainder of 2^PHASE_BITS.
	localparam int WAVE_D = PATTERN_STEPS - 1;
	localparam int WAVE_Q = (2 ** PHASE_BITS) / WAVE_D;
	localparam int WAVE_R = (2 ** PHASE_BITS) % WAVE_D;
	localparam int RAMP_D = PATTERN_STEPS;
	localparam int RAMP_Q = (2 ** PHASE_BITS) / RAMP_D;
	localparam int RAMP_R = (2 ** PHASE_BITS) % RAMP_D;

	localparam logic [STEP_W-1:0]     LAST_STEP = STEP_W'(PATTERN_STEPS - 1);
	localparam logic [PHASE_BITS-1:0] HALF_TURN = {1'b1, {(PHASE_BITS - 1){1'b0}}};
	localparam logic [PHASE_BITS:0]   FULL_TURN = {1'b1, {PHASE_BITS{1'b0}}};

	logic adv;
	logic accept;

	// Sequencer and held request.
	logic                          busy_q;
	logic [STEP_W-1:0]             step_q;
	logic [PHASE_BITS-1:0]         wave_q;
	logic [REM_W-1:0]              wave_rem_q;
	logic [PHASE_BITS-1:0]         ramp_q;
	logic [REM_W-1:0]              ramp_rem_q;
	rgbpg_pkg::shape_t             held_shape_q;
	logic                          held_rise_q;
	logic                          held_fall_q;
	logic [2:0][7:0]               held_colour_q;
	logic [2:0][PHASE_BITS-1:0]    held_phase_q;
	logic [7:0]                    held_delay_q;
	logic [7:0]                    held_repeat_q;
	logic [7:0]                    held_smooth_q;

	rgbpg_pkg::shape_t             dec_shape;
	logic                          dec_rise;
	logic                          dec_fall;
	logic [2:0][15:0]              req_shift;
	logic [2:0][PHASE_BITS+15:0]   shift_ext;
	logic [REM_W-1:0]              wave_sum;
	logic                          wave_wrap;
	logic [REM_W-1:0]              ramp_sum;
	logic                          ramp_wrap;

	// Pipeline stages.
	logic                          valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	rgbpg_pkg::side_t              side_n1, side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [2:0][PHASE_BITS-1:0]    phase_n1, phase_s1;
	logic [2:0][15:0]              a_n2, b_n2, a_s2, a_s3;
	logic [2:0]                    down_n2, down_s2, down_s3;
	logic [2:0][rgbpg_pkg::DIFF_W-1:0] diff_n2, diff_s2;
	logic [2:0][FW-1:0]            frac_s2;
	logic [2:0][PHASE_BITS:0]      rop_n2, rop_s2, rop_s3;
	logic [2:0][PW-1:0]            prod_s3;
	logic [2:0][15:0]              raised_n4;
	logic [2:0][OPW-1:0]           opnd_n4, opnd_s4;
	logic [2:0][XW-1:0]            x_s5;
	logic [2:0][7:0]               level_n6;
	logic [2:0][16:0]              rem_n6;
	rgbpg_pkg::step_t              step_n6, step_s6;

	assign adv       = !valid_s6 || step_ready;
	assign req_ready = !busy_q || (adv && step_q == LAST_STEP);
	assign accept    = req_valid && req_ready;

	// Mode decode and request-side conversions.
	always_comb begin
		dec_shape = rgbpg_pkg::SHAPE_CONST;
		dec_rise  = 1'b0;
		dec_fall  = 1'b0;
		unique case (req.pattern_mode)
			rgbpg_pkg::MODE_FALL_WAVE: begin
				dec_shape = rgbpg_pkg::SHAPE_WAVE;
			end
			rgbpg_pkg::MODE_RISE_WAVE: begin
				dec_shape = rgbpg_pkg::SHAPE_WAVE;
				dec_rise  = 1'b1;
			end
			rgbpg_pkg::MODE_RISE_RAMP: begin
				dec_shape = rgbpg_pkg::SHAPE_RAMP;
			end
			rgbpg_pkg::MODE_FALL_RAMP: begin
				dec_shape = rgbpg_pkg::SHAPE_RAMP;
				dec_fall  = 1'b1;
			end
			default: begin
				dec_shape = rgbpg_pkg::SHAPE_CONST;
			end
		endcase
		req_shift[0] = req.red_shift;
		req_shift[1] = req.green_shift;
		req_shift[2] = req.blue_shift;
		// A 16-bit turn fraction rescaled to PHASE_BITS, truncated.
		for (int c = 0; c < 3; c++) begin
			shift_ext[c] = {req_shift[c], {PHASE_BITS{1'b0}}};
		end
	end

	// Running quotient/remainder of i * 2^PHASE_BITS over the step divisors.
	always_comb begin
		wave_sum  = wave_rem_q + REM_W'(WAVE_R);
		wave_wrap = wave_sum >= REM_W'(WAVE_D);
		ramp_sum  = ramp_rem_q + REM_W'(RAMP_R);
		ramp_wrap = ramp_sum >= REM_W'(RAMP_D);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			step_q     <= '0;
			wave_q     <= '0;
			wave_rem_q <= '0;
			ramp_q     <= '0;
			ramp_rem_q <= '0;
		end else begin
			if (busy_q && adv) begin
				step_q     <= step_q + STEP_W'(1);
				wave_q     <= wave_q + PHASE_BITS'(WAVE_Q) + PHASE_BITS'(wave_wrap);
				wave_rem_q <= wave_wrap ? wave_sum - REM_W'(WAVE_D) : wave_sum;
				ramp_q     <= ramp_q + PHASE_BITS'(RAMP_Q) + PHASE_BITS'(ramp_wrap);
				ramp_rem_q <= ramp_wrap ? ramp_sum - REM_W'(RAMP_D) : ramp_sum;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
			if (accept) begin
				busy_q     <= 1'b1;
				step_q     <= '0;
				wave_q     <= '0;
				wave_rem_q <= '0;
				ramp_q     <= '0;
				ramp_rem_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_shape_q     <= dec_shape;
			held_rise_q      <= dec_rise;
			held_fall_q      <= dec_fall;
			held_colour_q[0] <= req.red;
			held_colour_q[1] <= req.green;
			held_colour_q[2] <= req.blue;
			for (int c = 0; c < 3; c++) begin
				held_phase_q[c] <= shift_ext[c][PHASE_BITS+15:16];
			end
			held_delay_q     <= rgbpg_pkg::delay_code(req.start_delay_ms);
			held_repeat_q    <= rgbpg_pkg::delay_code(req.repeat_delay_ms);
			held_smooth_q    <= req.smoothing;
		end
	end

	// Stage 1 input: per-channel phase of the step being issued.
	always_comb begin
		side_n1.step_index  = 5'(step_q);
		side_n1.last_step   = (step_q == LAST_STEP);
		side_n1.shape       = held_shape_q;
		side_n1.ramp_fall   = held_fall_q;
		side_n1.colour      = held_colour_q;
		side_n1.delay_code  = held_delay_q;
		side_n1.repeat_code = held_repeat_q;
		side_n1.smooth_code = held_smooth_q;
		for (int c = 0; c < 3; c++) begin
			if (held_shape_q == rgbpg_pkg::SHAPE_WAVE) begin
				phase_n1[c] = wave_q + held_phase_q[c] + (held_rise_q ? HALF_TURN : '0);
			end else begin
				phase_n1[c] = ramp_q + held_phase_q[c];
			end
		end
	end

	// Stage 2 input: cosine table points around the phase, ramp operand.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			a_n2[c]    = rgbpg_pkg::raised_point(phase_s1[c][PHASE_BITS-1 -: 6]);
			b_n2[c]    = rgbpg_pkg::raised_point(phase_s1[c][PHASE_BITS-1 -: 6] + 6'd1);
			down_n2[c] = b_n2[c] < a_n2[c];
			diff_n2[c] = down_n2[c] ? rgbpg_pkg::DIFF_W'(a_n2[c] - b_n2[c])
			                        : rgbpg_pkg::DIFF_W'(b_n2[c] - a_n2[c]);
			rop_n2[c]  = side_s1.ramp_fall ? FULL_TURN - {1'b0, phase_s1[c]}
			                               : {1'b0, phase_s1[c]};
		end
	end

	// Stage 4 input: interpolated raised cosine, or the ramp operand.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			raised_n4[c] = down_s3[c]
				? a_s3[c] - 16'(prod_s3[c][PW-1:FW])
				: a_s3[c] + 16'(prod_s3[c][PW-1:FW]);
			opnd_n4[c]   = (side_s3.shape == rgbpg_pkg::SHAPE_WAVE) ? OPW'(raised_n4[c])
			                                                        : OPW'(rop_s3[c]);
		end
	end

	// Stage 6 input: scale the product back to a level. For the wave the
	// divisor 65534 is handled as a shift by 16 plus one correction step.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rem_n6[c] = {1'b0, x_s5[c][15:0]} + {8'b0, x_s5[c][23:16], 1'b0};
			case (side_s5.shape)
				rgbpg_pkg::SHAPE_WAVE: begin
					level_n6[c] = (rem_n6[c] >= rgbpg_pkg::WAVE_DIV)
						? x_s5[c][23:16] + 8'd1 : x_s5[c][23:16];
				end
				rgbpg_pkg::SHAPE_RAMP: begin
					level_n6[c] = x_s5[c][PHASE_BITS+7:PHASE_BITS];
				end
				default: begin
					level_n6[c] = side_s5.colour[c];
				end
			endcase
		end
		step_n6.step_index  = side_s5.step_index;
		step_n6.red_level   = level_n6[0];
		step_n6.green_level = level_n6[1];
		step_n6.blue_level  = level_n6[2];
		step_n6.delay_code  = side_s5.delay_code;
		step_n6.repeat_code = side_s5.repeat_code;
		step_n6.smooth_code = side_s5.smooth_code;
		step_n6.last_step   = side_s5.last_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= busy_q;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1  <= side_n1;
			phase_s1 <= phase_n1;

			side_s2  <= side_s1;
			a_s2     <= a_n2;
			down_s2  <= down_n2;
			diff_s2  <= diff_n2;
			rop_s2   <= rop_n2;
			for (int c = 0; c < 3; c++) begin
				frac_s2[c] <= phase_s1[c][FW-1:0];
			end

			side_s3  <= side_s2;
			a_s3     <= a_s2;
			down_s3  <= down_s2;
			rop_s3   <= rop_s2;
			for (int c = 0; c < 3; c++) begin
				prod_s3[c] <= PW'(diff_s2[c]) * PW'(frac_s2[c]);
			end

			side_s4  <= side_s3;
			opnd_s4  <= opnd_n4;

			side_s5  <= side_s4;
			for (int c = 0; c < 3; c++) begin
				x_s5[c] <= XW'(opnd_s4[c]) * XW'(side_s4.colour[c]);
			end

			step_s6  <= step_n6;
		end
	end

	assign step_valid = valid_s6;
	assign step       = step_s6;

	// The last step word of a pattern carries the final step number.
	assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && step.last_step |-> step.step_index == 5'(PATTERN_STEPS - 1))
		else $error("last_step flagged on a step other than the final one");

	// A new request is only taken when the sequencer is free or finishing.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !busy_q || step_q == LAST_STEP)
		else $error("request accepted while a pattern is still being issued");

	// A stalled sequencer keeps its place in the pattern.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !adv && !accept |=> busy_q && $stable(step_q) && $stable(wave_q))
		else $error("sequencer moved during an output stall");

	// After the final step is issued without a new request, the sequencer idles.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && adv && step_q == LAST_STEP && !accept |=> !busy_q)
		else $error("sequencer did not stop after the final step");

endmodule

`default_nettype wire
